>>> hw/rtl/rsput_pkg.sv
// Shared widths and operation codes for the range-sum point-update tree.
`default_nettype none

package rsput_pkg;

	localparam int POS_W = 11;
	localparam int VAL_W = 32;
	localparam int SUM_W = 64;

	localparam logic OP_QUERY = 1'b0;
	localparam logic OP_SET   = 1'b1;

endpackage

`default_nettype wire

>>> hw/rtl/rsput_req_if.sv
// Request channel: one operation word with valid/ready handshake.
`default_nettype none

interface rsput_req_if;
	import rsput_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    op;
	logic        [POS_W-1:0] first_pos;
	logic        [POS_W-1:0] last_pos;
	logic signed [VAL_W-1:0] new_value;

	modport source (
		output valid, op, first_pos, last_pos, new_value,
		input  ready
	);

	modport sink (
		input  valid, op, first_pos, last_pos, new_value,
		output ready
	);
endinterface

`default_nettype wire

>>> hw/rtl/rsput_rsp_if.sv
// Response channel: one range-sum word with valid/ready handshake.
`default_nettype none

interface rsput_rsp_if;
	import rsput_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [SUM_W-1:0] range_sum;

	modport source (
		output valid, range_sum,
		input  ready
	);

	modport sink (
		input  valid, range_sum,
		output ready
	);
endinterface

`default_nettype wire

>>> hw/rtl/rsput_decode.sv
// Request decode: set position check, range swap and clamp, tree node indexes.
`default_nettype none

module rsput_decode #(
	parameter int SIZE = 1024
) (
	input  wire logic [rsput_pkg::POS_W-1:0]     first_pos,
	input  wire logic [rsput_pkg::POS_W-1:0]     last_pos,
	output logic                                 set_ok,
	output logic [$clog2(2*SIZE)-1:0]            leaf_idx,
	output logic [$clog2(2*SIZE+1)-1:0]          lo_idx,
	output logic [$clog2(2*SIZE+1)-1:0]          hi_idx
);
	import rsput_pkg::*;

	localparam int ADDR_W = $clog2(2*SIZE);
	localparam int NODE_W = $clog2(2*SIZE+1);

	logic [POS_W-1:0] lo_raw;
	logic [POS_W-1:0] hi_raw;
	logic [31:0]      a32;
	logic [31:0]      lo32;
	logic [31:0]      hi32;
	logic [31:0]      leaf32;
	logic [31:0]      l32;
	logic [31:0]      r32;
	logic             empty;

	// Validate set position and map it to its leaf node
	always_comb begin
		a32    = 32'(first_pos);
		set_ok = (first_pos != '0) && (a32 <= 32'(SIZE));
		leaf32 = 32'(SIZE) + a32 - 32'd1;
		leaf_idx = leaf32[ADDR_W-1:0];
	end

	// Order the ends, clamp to the store, form half-open node bounds
	always_comb begin
		if (first_pos > last_pos) begin
			lo_raw = last_pos;
			hi_raw = first_pos;
		end else begin
			lo_raw = first_pos;
			hi_raw = last_pos;
		end
		lo32  = (lo_raw == '0) ? 32'd1 : 32'(lo_raw);
		hi32  = (32'(hi_raw) > 32'(SIZE)) ? 32'(SIZE) : 32'(hi_raw);
		empty = lo32 > hi32;
		l32   = 32'(SIZE) + lo32 - 32'd1;
		r32   = 32'(SIZE) + hi32;
		// An empty range gets equal bounds so the walk ends at once
		lo_idx = empty ? '0 : l32[NODE_W-1:0];
		hi_idx = empty ? '0 : r32[NODE_W-1:0];
	end

endmodule

`default_nettype wire

>>> hw/rtl/range_sum_point_update_tree.sv
// Top level: array sum tree in one node memory with set and range-sum walks.
//
//   channel | dir | handshake   | word
//   --------+-----+-------------+---------------------------------------------
//   req     | in  | valid/ready | op, first_pos, last_pos, new_value
//   rsp     | out | valid/ready | range_sum (one per query, none per set)
//
// A set writes its leaf in ST_SET_LEAF and then each parent up to the root
// in ST_SET_UP; a set outside the store is dropped in its accept cycle. A
// query walks both bounds up the tree in ST_Q_RUN, fewer levels for a short
// range, then passes ST_Q_D1 and ST_Q_D2. Each tree level is one step of the
// node memory (one read and one write per level for a set, two reads per
// level for a query). After reset a clearing pass writes zero to all 2*SIZE
// nodes, one per cycle, with req.ready low. A stalled rsp holds its word; a
// query only waits at its end for the output register.
`default_nettype none

module range_sum_point_update_tree #(
	parameter int SIZE = 1024
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rsput_req_if.sink  req,
	rsput_rsp_if.source rsp
);
	import rsput_pkg::*;

	localparam int ADDR_W = $clog2(2*SIZE);
	localparam int NODE_W = $clog2(2*SIZE+1);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_CLEAR    = 3'd1;
	localparam logic [2:0] ST_SET_LEAF = 3'd2;
	localparam logic [2:0] ST_SET_UP   = 3'd3;
	localparam logic [2:0] ST_Q_RUN    = 3'd4;
	localparam logic [2:0] ST_Q_D1     = 3'd5;
	localparam logic [2:0] ST_Q_D2     = 3'd6;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] clr_q;

	// Decoded request
	logic              set_ok;
	logic [ADDR_W-1:0] leaf_idx;
	logic [NODE_W-1:0] lo_idx;
	logic [NODE_W-1:0] hi_idx;

	// Set walk
	logic [ADDR_W-1:0] idx_q;
	logic [SUM_W-1:0]  cur_q;
	logic [ADDR_W-1:0] par_idx;
	logic [SUM_W-1:0]  up_sum;

	// Query walk
	logic [NODE_W-1:0] l_q;
	logic [NODE_W-1:0] r_q;
	logic [NODE_W-1:0] r_dec;
	logic              q_issue;
	logic              v_s1;
	logic              ta_s1;
	logic              tb_s1;
	logic              v_s2;
	logic [SUM_W-1:0]  pair_s2;
	logic [SUM_W-1:0]  acc_q;

	// Node memory
	logic [SUM_W-1:0]  node_mem [2*SIZE];
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [SUM_W-1:0]  mem_wdata;
	logic [ADDR_W-1:0] mem_ra;
	logic [ADDR_W-1:0] mem_rb;
	logic [SUM_W-1:0]  rd_a_q;
	logic [SUM_W-1:0]  rd_b_q;

	// Output register
	logic              out_valid_q;
	logic [SUM_W-1:0]  out_sum_q;
	logic              out_free;
	logic              req_acc;

	rsput_decode #(
		.SIZE (SIZE)
	) u_decode (
		.first_pos (req.first_pos),
		.last_pos  (req.last_pos),
		.set_ok    (set_ok),
		.leaf_idx  (leaf_idx),
		.lo_idx    (lo_idx),
		.hi_idx    (hi_idx)
	);

	assign req.ready     = (state_q == ST_IDLE);
	assign req_acc       = req.valid && req.ready;
	assign rsp.valid     = out_valid_q;
	assign rsp.range_sum = out_sum_q;
	assign out_free      = !out_valid_q || rsp.ready;

	assign par_idx = {1'b0, idx_q[ADDR_W-1:1]};
	assign up_sum  = cur_q + rd_a_q;
	assign r_dec   = r_q - NODE_W'(1);
	assign q_issue = (state_q == ST_Q_RUN) && (l_q < r_q);

	// Steer the memory ports by state
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = cur_q;
		mem_ra    = l_q[ADDR_W-1:0];
		mem_rb    = r_dec[ADDR_W-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_SET_LEAF: begin
				mem_we = 1'b1;
				mem_ra = idx_q ^ ADDR_W'(1);
			end
			ST_SET_UP: begin
				mem_we    = 1'b1;
				mem_waddr = par_idx;
				mem_wdata = up_sum;
				mem_ra    = par_idx ^ ADDR_W'(1);
			end
			default: begin
			end
		endcase
	end

	// Node memory: one write, two registered reads
	always_ff @(posedge clk) begin
		if (mem_we) begin
			node_mem[mem_waddr] <= mem_wdata;
		end
		rd_a_q <= node_mem[mem_ra];
		rd_b_q <= node_mem[mem_rb];
	end

	// Sequencer and control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= q_issue;
			v_s2 <= v_s1;
			// Load a finished sum, or drop the word once it is taken
			if (state_q == ST_Q_D2 && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(2*SIZE-1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_acc) begin
						if (req.op == OP_QUERY) begin
							state_q <= ST_Q_RUN;
						end else if (set_ok) begin
							state_q <= ST_SET_LEAF;
						end
					end
				end
				ST_SET_LEAF: begin
					state_q <= ST_SET_UP;
				end
				ST_SET_UP: begin
					if (par_idx == ADDR_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_Q_RUN: begin
					if (!q_issue) begin
						state_q <= ST_Q_D1;
					end
				end
				ST_Q_D1: begin
					state_q <= ST_Q_D2;
				end
				ST_Q_D2: begin
					// Hold the finished sum until the output register frees
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Walk registers and datapath
	always_ff @(posedge clk) begin
		ta_s1   <= l_q[0];
		tb_s1   <= r_q[0];
		pair_s2 <= (v_s1 && ta_s1 ? rd_a_q : '0) + (v_s1 && tb_s1 ? rd_b_q : '0);
		if (v_s2) begin
			acc_q <= acc_q + pair_s2;
		end
		if (req_acc) begin
			idx_q <= leaf_idx;
			cur_q <= SUM_W'(req.new_value);
			l_q   <= lo_idx;
			r_q   <= hi_idx;
			acc_q <= '0;
		end
		// Advance one level up the tree
		if (state_q == ST_SET_UP) begin
			cur_q <= up_sum;
			idx_q <= par_idx;
		end
		if (q_issue) begin
			l_q <= (l_q + NODE_W'(l_q[0])) >> 1;
			r_q <= r_q >> 1;
		end
		if (state_q == ST_Q_D2 && out_free) begin
			out_sum_q <= acc_q;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/rsput_checker.sv
// Port-level checks for the range-sum point-update tree, bound to the top level.
`default_nettype none

module rsput_port_props (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          req_valid,
	input wire logic                          req_ready,
	input wire logic                          req_op,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic [rsput_pkg::SUM_W-1:0]   rsp_range_sum
);
	import rsput_pkg::*;

	// Hold a stalled response word
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp valid dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_range_sum))
		else $error("rsp word changed while stalled");

	// A query occupies the block: no second word in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_op == OP_QUERY |=> !req_ready)
		else $error("req ready right after a query was taken");

	// No result appears the cycle after a request is taken with rsp_valid low
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !rsp_valid |=> !rsp_valid)
		else $error("rsp appeared one cycle after a request");

endmodule

bind range_sum_point_update_tree rsput_port_props u_rsput_port_props (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_op        (req.op),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_range_sum (rsp.range_sum)
);

`default_nettype wire

>>> sim/rsput_checker.sv
// Checker for the range-sum tree: predicts each sum from observed words and compares results.
module rsput_checker #(
	parameter int SIZE = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rsput_req_if      req,
	rsput_rsp_if      rsp,
	output int        fail_count,
	output int        outstanding
);
	import rsput_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow of the stored values, one entry per 1-based position
	logic [SUM_W-1:0] leaf_vals [1:SIZE];
	logic [SUM_W-1:0] pending_sums [$];
	int               mismatches;

	// Sum over the inclusive range after ordering and clamping the ends
	function automatic logic [SUM_W-1:0] span_total(input int a, input int b);
		int               lo;
		int               hi;
		int               p;
		logic [SUM_W-1:0] acc;
		lo = (a > b) ? b : a;
		hi = (a > b) ? a : b;
		if (lo < 1) lo = 1;
		if (hi > SIZE) hi = SIZE;
		acc = '0;
		for (p = lo; p <= hi; p++) acc += leaf_vals[p];
		return acc;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [SUM_W-1:0] want;
		int               pos;
		if (!arst_n) begin
			foreach (leaf_vals[i]) leaf_vals[i] = '0;
			pending_sums.delete();
			mismatches = 0;
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			// Compare an accepted result word against the oldest pending sum
			if (rsp.valid && rsp.ready) begin
				if (pending_sums.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected range_sum word %0d", $realtime,
						$signed(rsp.range_sum));
				end else begin
					want = pending_sums.pop_front();
					if (rsp.range_sum !== want) begin
						mismatches++;
						$display("%0t: range_sum mismatch: expected %0d, actual %0d",
							$realtime, $signed(want), $signed(rsp.range_sum));
					end
				end
			end
			// Apply a set or queue the sum for a query
			if (req.valid && req.ready) begin
				pos = int'(req.first_pos);
				if (req.op == OP_SET) begin
					if (pos >= 1 && pos <= SIZE)
						leaf_vals[pos] = {{(SUM_W-VAL_W){req.new_value[VAL_W-1]}}, req.new_value};
				end else begin
					pending_sums.push_back(span_total(pos, int'(req.last_pos)));
				end
			end
			fail_count  <= mismatches;
			outstanding <= pending_sums.size();
		end
	end

endmodule

>>> sim/tb_range_sum_point_update_tree.sv
// Testbench top for the range-sum tree: clock, reset, stimulus, flow control and verdict.
module tb_range_sum_point_update_tree;
	import rsput_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SIZE         = 1024;
	localparam int PHASE_WORDS  = 560;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic                    op;
		logic        [POS_W-1:0] first_pos;
		logic        [POS_W-1:0] last_pos;
		logic signed [VAL_W-1:0] new_value;
	} tree_op_t;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   outstanding;
	int   tx_idle_pct;
	int   rx_idle_pct;
	int   hold_orders;
	int   hold_served;
	int   hold_left;
	int   cycle_count;

	rsput_req_if req_bus ();
	rsput_rsp_if rsp_bus ();

	range_sum_point_update_tree #(.SIZE(SIZE)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus.sink),
		.rsp    (rsp_bus.source)
	);

	rsput_checker #(.SIZE(SIZE)) sum_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_bus),
		.rsp         (rsp_bus),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always #4 clk = ~clk;

	// Random position: mostly inside the store, sometimes anywhere the field reaches
	function automatic logic [POS_W-1:0] pick_pos();
		if ($urandom_range(99) < 8) return POS_W'($urandom_range((1 << POS_W) - 1));
		return POS_W'($urandom_range(SIZE, 1));
	endfunction

	function automatic tree_op_t random_op();
		tree_op_t w;
		w.op        = ($urandom_range(99) < 55) ? OP_SET : OP_QUERY;
		w.first_pos = pick_pos();
		w.last_pos  = pick_pos();
		// Keep some queries narrow around the first end
		if (w.op == OP_QUERY && $urandom_range(3) == 0 && w.first_pos <= SIZE)
			w.last_pos = w.first_pos + POS_W'($urandom_range(3));
		case ($urandom_range(9))
			0:       w.new_value = 32'sh7fff_ffff;
			1:       w.new_value = 32'sh8000_0000;
			2:       w.new_value = VAL_W'($signed($urandom_range(16)) - 8);
			default: w.new_value = $urandom();
		endcase
		return w;
	endfunction

	function automatic tree_op_t make_op(input logic op, input int a, input int b,
			input logic [VAL_W-1:0] v);
		tree_op_t w;
		w.op        = op;
		w.first_pos = POS_W'(a);
		w.last_pos  = POS_W'(b);
		w.new_value = v;
		return w;
	endfunction

	// Offer one word after random idle cycles and hold it until accepted
	task automatic send_word(input tree_op_t w);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
		req_bus.valid     <= 1'b1;
		req_bus.op        <= w.op;
		req_bus.first_pos <= w.first_pos;
		req_bus.last_pos  <= w.last_pos;
		req_bus.new_value <= w.new_value;
		do @(posedge clk); while (!req_bus.ready);
	endtask

	task automatic send_random(input int count);
		repeat (count) send_word(random_op());
	endtask

	// Drive every input to a known value and pulse reset once
	initial begin
		arst_n            <= 1'b0;
		req_bus.valid     <= 1'b0;
		req_bus.op        <= OP_QUERY;
		req_bus.first_pos <= '0;
		req_bus.last_pos  <= '0;
		req_bus.new_value <= '0;
		rsp_bus.ready     <= 1'b0;
		tx_idle_pct       <= 36;
		rx_idle_pct       <= 48;
		hold_orders       <= 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Drive the receiver: long hold on request, otherwise random stalls
	initial begin
		hold_served = 0;
		hold_left   = 0;
		forever begin
			@(posedge clk);
			if (hold_orders != hold_served) begin
				hold_served = hold_orders;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Stop a hung run
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// Stimulus: directed corners, then random phases with changing idle rates
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);

		// Empty store, full range and out-of-store ends
		send_word(make_op(OP_QUERY, 1, SIZE, 32'h1234_5678));
		send_word(make_op(OP_QUERY, 0, 2047, '0));
		// Extreme values at the first and last position
		send_word(make_op(OP_SET, 1, 2047, 32'h7fff_ffff));
		send_word(make_op(OP_SET, SIZE, 0, 32'h8000_0000));
		send_word(make_op(OP_QUERY, 1, SIZE, '0));
		send_word(make_op(OP_QUERY, SIZE, 1, 32'hffff_ffff));
		// Sets outside the store are dropped
		send_word(make_op(OP_SET, 0, 5, 32'h0000_0100));
		send_word(make_op(OP_SET, SIZE + 1, 5, 32'h0000_0200));
		send_word(make_op(OP_SET, 2047, 2047, 32'hffff_ffff));
		send_word(make_op(OP_QUERY, 0, 2047, '0));
		// Single positions and overwrite of a value
		send_word(make_op(OP_SET, 5, 0, 32'hffff_fffb));
		send_word(make_op(OP_QUERY, 5, 5, '0));
		send_word(make_op(OP_SET, 5, 0, 32'h0000_0007));
		send_word(make_op(OP_QUERY, 5, 5, '0));
		send_word(make_op(OP_QUERY, 1, 1, '0));
		send_word(make_op(OP_QUERY, SIZE, SIZE, '0));
		// Ranges that are empty after clamping
		send_word(make_op(OP_QUERY, 0, 0, 32'h7fff_ffff));
		send_word(make_op(OP_QUERY, 2047, SIZE + 1, '0));
		// Ends clamped on one side only
		send_word(make_op(OP_QUERY, 6, 0, '0));
		send_word(make_op(OP_QUERY, 2047, 5, '0));

		send_random(PHASE_WORDS);

		tx_idle_pct <= 48;
		rx_idle_pct <= 36;
		send_random(PHASE_WORDS);

		// No idling; receiver holds off while words keep coming
		tx_idle_pct <= 0;
		rx_idle_pct <= 0;
		hold_orders <= hold_orders + 1;
		send_random(PHASE_WORDS);
		req_bus.valid <= 1'b0;

		// Let the count of pending sums settle after the last accept
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
